// ===== hdl/mns_pkg.sv =====
package mns_pkg;

    // storage geometry
    localparam int NOTE_AW      = 8;
    localparam int NOTE_DEPTH   = 1 << NOTE_AW;
    localparam int MEL_AW       = 3;
    localparam int MAX_MELODIES = 1 << MEL_AW;

    // field widths
    localparam int FREQ_W  = 12;
    localparam int TICK_W  = 8;
    localparam int DUTY_W  = 10;
    localparam int CNT_W   = 4;
    localparam int ENTRY_W = FREQ_W + TICK_W;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 10;

    // configuration register indexes and reset values
    localparam logic [CFG_AW-1:0] CFG_MELODY_COUNT = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_TONE_DUTY    = 1'd1;
    localparam logic [CNT_W-1:0]  MELODY_COUNT_RST = 4'd5;
    localparam logic [DUTY_W-1:0] TONE_DUTY_RST    = 10'd512;

    typedef enum logic [1:0] {
        OP_WRITE_NOTE  = 2'd0,
        OP_WRITE_START = 2'd1,
        OP_LOAD        = 2'd2,
        OP_TICK        = 2'd3
    } t_op;

    typedef struct packed {
        logic [MEL_AW-1:0]  melody_number;
        logic [TICK_W-1:0]  note_ticks;
        logic [FREQ_W-1:0]  note_freq;
        logic [NOTE_AW-1:0] address;
        t_op                operation;
    } t_item;

    typedef struct packed {
        logic [MEL_AW-1:0]  melody_current;
        logic [NOTE_AW-1:0] note_position;
        logic               melody_done;
        logic               is_playing;
        logic [DUTY_W-1:0]  tone_duty_out;
        logic [FREQ_W-1:0]  tone_freq_hz;
    } t_result;

    // melody number modulo count, count of zero acts as one
    function automatic logic [MEL_AW-1:0] mel_mod(input logic [MEL_AW-1:0] mnum,
                                                  input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] rem;
        logic [CNT_W-1:0] c;
        rem = CNT_W'(mnum);
        c   = (cnt == '0) ? CNT_W'(1) : cnt;
        for (int i = 0; i < MAX_MELODIES; i++) begin
            if (rem >= c) begin
                rem = rem - c;
            end
        end
        return rem[MEL_AW-1:0];
    endfunction

endpackage

// ===== hdl/mns_note_ram.sv =====
module mns_note_ram
    import mns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [NOTE_AW-1:0] i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [NOTE_AW-1:0] i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [NOTE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mns_seq.sv =====
module mns_seq
    import mns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_item             i_item,
    input  logic              i_out_free,
    input  logic [CNT_W-1:0]  i_melody_count,
    input  logic [DUTY_W-1:0] i_tone_duty,
    output logic              o_idle,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [MEL_AW-1:0]   r_mel;
    logic [NOTE_AW-1:0]  r_load_addr;
    logic [NOTE_AW-1:0]  r_ptr, n_ptr;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic                r_playing, n_playing;
    logic [FREQ_W-1:0]   r_freq, n_freq;
    logic                r_sounding, n_sounding;
    logic [MEL_AW-1:0]   r_loaded, n_loaded;
    logic                n_done;
    logic [NOTE_AW-1:0]  r_starts [MAX_MELODIES];

    logic [MEL_AW-1:0]   sel_mel;
    logic [NOTE_AW-1:0]  rd_addr;
    logic [NOTE_AW-1:0]  ptr_next;
    logic [ENTRY_W-1:0]  rdata;
    logic [FREQ_W-1:0]   rd_freq;
    logic [TICK_W-1:0]   rd_ticks;
    logic                finish;

    assign sel_mel  = mel_mod(i_item.melody_number, i_melody_count);
    assign ptr_next = r_ptr + NOTE_AW'(1);
    assign rd_addr  = (i_item.operation == OP_LOAD) ? r_starts[sel_mel] : ptr_next;
    assign rd_freq  = rdata[ENTRY_W-1:TICK_W];
    assign rd_ticks = rdata[TICK_W-1:0];
    assign finish   = (r_state == ST_READ) && i_out_free;

    // note store, written on accept, read for load and tick
    mns_note_ram u_note_ram (
        .i_clk   (i_clk),
        .i_we    (i_accept && (i_item.operation == OP_WRITE_NOTE)),
        .i_waddr (i_item.address),
        .i_wdata ({i_item.note_freq, i_item.note_ticks}),
        .i_re    (i_accept),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // melody start table
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_item.operation == OP_WRITE_START)) begin
            r_starts[i_item.melody_number] <= i_item.address;
        end
    end

    // captured item fields
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_op        <= i_item.operation;
            r_mel       <= sel_mel;
            r_load_addr <= r_starts[sel_mel];
        end
    end

    // state update once the note entry is back
    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_ticks    = r_ticks;
        n_playing  = r_playing;
        n_freq     = r_freq;
        n_sounding = r_sounding;
        n_loaded   = r_loaded;
        n_done     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                    case (r_op)
                        OP_LOAD: begin
                            n_loaded  = r_mel;
                            n_ptr     = r_load_addr;
                            n_ticks   = rd_ticks;
                            n_playing = 1'b1;
                            if (rd_freq == '0) begin
                                n_sounding = 1'b0;
                            end else begin
                                n_freq     = rd_freq;
                                n_sounding = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (r_playing) begin
                                if (r_ticks != '0) begin
                                    n_ticks = r_ticks - TICK_W'(1);
                                end else begin
                                    n_ptr = ptr_next;
                                    if ((rd_freq == '0) && (rd_ticks == '0)) begin
                                        n_sounding = 1'b0;
                                        n_playing  = 1'b0;
                                        n_done     = 1'b1;
                                    end else begin
                                        n_ticks = rd_ticks;
                                        if (rd_freq == '0) begin
                                            n_sounding = 1'b0;
                                        end else begin
                                            n_freq     = rd_freq;
                                            n_sounding = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ptr      <= '0;
            r_ticks    <= '0;
            r_playing  <= 1'b0;
            r_freq     <= '0;
            r_sounding <= 1'b0;
            r_loaded   <= '0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_ticks    <= n_ticks;
            r_playing  <= n_playing;
            r_freq     <= n_freq;
            r_sounding <= n_sounding;
            r_loaded   <= n_loaded;
        end
    end

    // result beat built from the next state
    always_comb begin
        o_res.tone_freq_hz   = n_freq;
        o_res.tone_duty_out  = n_sounding ? i_tone_duty : '0;
        o_res.is_playing     = n_playing;
        o_res.melody_done    = n_done;
        o_res.note_position  = n_ptr;
        o_res.melody_current = n_loaded;
    end

    assign o_res_valid = finish;
    assign o_idle      = (r_state == ST_IDLE);

endmodule

// ===== hdl/melody_note_sequencer_top.sv =====
// melody note sequencer
// input channel (s side): one beat per operation; tuser carries the operation
// code (write note, write melody start, load melody, tick), tdata the address,
// note frequency, note ticks and melody number.
// output channel (m side): one result beat for every input beat, carrying the
// tone frequency, the duty now driven, playing flag, note position and the
// melody loaded last; tlast is high on the tick that hit the end marker.
// configuration: i_cfg_we writes register i_cfg_addr (0 melody count,
// 1 tone duty) with i_cfg_data at the clock edge; write only while idle.
// the note store read registers the entry when the input beat is taken; the
// update then lands in the output register once that output register is free.
// a new operation is accepted only once the previous one has finished.
// reset (synchronous, active low) stops playback, clears pointer, counters
// and output valid; the note store and start table hold garbage until written.
// when the receiver stalls, the finished result stays in the output register;
// one more beat may be accepted and then waits in the sequencer until the
// output register frees up.
module melody_note_sequencer_top
    import mns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // s side
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // address, note_freq, note_ticks, melody_number
    input  logic [1:0]        s_axis_tuser,   // operation
    // m side
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // tone_freq_hz, tone_duty_out, is_playing,
                                              // note_position, melody_current
    output logic              m_axis_tlast,   // melody_done
    // configuration
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic [CNT_W-1:0]  r_melody_count;
    logic [DUTY_W-1:0] r_tone_duty;
    logic              r_out_valid;
    t_result           r_out;
    t_item             item;
    logic              accept;
    logic              idle;
    logic              res_valid;
    logic              out_free;
    t_result           res;

    // unpack input beat
    assign item.operation     = t_op'(s_axis_tuser);
    assign item.address       = s_axis_tdata[7:0];
    assign item.note_freq     = s_axis_tdata[19:8];
    assign item.note_ticks    = s_axis_tdata[27:20];
    assign item.melody_number = s_axis_tdata[30:28];

    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && idle;
    assign out_free      = !r_out_valid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_melody_count <= MELODY_COUNT_RST;
            r_tone_duty    <= TONE_DUTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MELODY_COUNT: r_melody_count <= i_cfg_data[CNT_W-1:0];
                CFG_TONE_DUTY:    r_tone_duty    <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mns_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (item),
        .i_out_free     (out_free),
        .i_melody_count (r_melody_count),
        .i_tone_duty    (r_tone_duty),
        .o_idle         (idle),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    // pack output beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.melody_done;
    assign m_axis_tdata  = {6'd0, r_out.melody_current, r_out.note_position,
                            r_out.is_playing, r_out.tone_duty_out, r_out.tone_freq_hz};

endmodule

// ===== hdl/mns_checker.sv =====
module mns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // one operation at a time: no beat taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // end of melody stops playback
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[22])
        else $error("done while still playing");

    // silent duty whenever no melody plays
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[22] |-> m_axis_tdata[21:12] == 10'd0)
        else $error("duty driven while not playing");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind melody_note_sequencer_top mns_checker u_mns_checker (.*);
